[design/tcr_pkg.sv]
package tcr_pkg;

	// fixed field widths of the result side
	localparam int unsigned TAG_W    = 32;
	localparam int unsigned RADIUS_W = 32;

	// fraction bits of the radius output (unsigned Q16.16)
	localparam int unsigned OUT_FRAC = 16;

endpackage

[design/tcr_sqrt_pipe.sv]
module tcr_sqrt_pipe #(
	parameter int unsigned LANES = 1,
	parameter int unsigned RW    = 8,
	parameter int unsigned SBW   = 1
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	input  logic [LANES-1:0][RW-1:0]                  in_rad,
	input  logic [SBW-1:0]                            in_sb,
	output logic                                      out_valid,
	output logic [LANES-1:0][(RW+1)/2-1:0]            out_root,
	output logic [SBW-1:0]                            out_sb
);

	localparam int unsigned RTW  = (RW + 1) / 2;
	localparam int unsigned PADW = 2 * RTW;
	localparam int unsigned REMW = RTW + 3;

	logic                             vld_s  [0:RTW];
	logic [LANES-1:0][REMW-1:0]       rem_s  [0:RTW-1];
	logic [LANES-1:0][RTW-1:0]        root_s [0:RTW];
	logic [LANES-1:0][PADW-1:0]       rad_s  [0:RTW-1];
	logic [SBW-1:0]                   sb_s   [0:RTW];

	// stage zero is the incoming item
	always_comb begin
		vld_s[0]  = in_valid;
		sb_s[0]   = in_sb;
		rem_s[0]  = '0;
		root_s[0] = '0;
		for (int l = 0; l < LANES; l++) begin
			rad_s[0][l] = PADW'(in_rad[l]);
		end
	end

	// one root bit per stage, restoring digit recurrence
	for (genvar k = 0; k < RTW; k++) begin : g_stage
		logic [LANES-1:0][REMW-1:0] acc;
		logic [LANES-1:0][REMW-1:0] trial;
		logic [LANES-1:0][REMW-1:0] nrem;
		logic [LANES-1:0][RTW-1:0]  nroot;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				acc[l]   = {rem_s[k][l][REMW-3:0], rad_s[k][l][PADW-1 -: 2]};
				trial[l] = {1'b0, root_s[k][l], 2'b01};
				if (acc[l] >= trial[l]) begin
					nrem[l]  = acc[l] - trial[l];
					nroot[l] = {root_s[k][l][RTW-2:0], 1'b1};
				end else begin
					nrem[l]  = acc[l];
					nroot[l] = {root_s[k][l][RTW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			root_s[k+1] <= nroot;
			sb_s[k+1]   <= sb_s[k];
		end

		// remainder and radicand are not needed past the last stage
		if (k < RTW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= nrem;
				for (int l = 0; l < LANES; l++) begin
					rad_s[k+1][l] <= {rad_s[k][l][PADW-3:0], 2'b00};
				end
			end
		end
	end

	assign out_valid = vld_s[RTW];
	assign out_root  = root_s[RTW];
	assign out_sb    = sb_s[RTW];

endmodule

[design/triangle_circumradius.sv]
// Circumradius of one triangle per cycle by Heron's formula. A triangle is
// taken at every clock edge where start is high; busy is always low because the
// pipeline never stalls. Each result appears on tag_out, radius and degenerate
// for exactly one cycle with done high, in input order, and must be captured
// then. The path runs from edge vectors and squared edges through the
// edge-length square root of depth E = COORD_WIDTH + 2 (one bit per stage),
// the Heron factor and product stages, the area square root of depth
// W = 2 * (COORD_WIDTH + 4), operand scaling, the 32 one-bit-per-stage radius
// divider stages and the output register. A zero area gives degenerate high
// and a radius of all ones; a radius beyond Q16.16 range saturates to all ones.
module triangle_circumradius #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [tcr_pkg::TAG_W-1:0]           triangle_id,
	input  logic signed [COORD_WIDTH-1:0]       ax,
	input  logic signed [COORD_WIDTH-1:0]       ay,
	input  logic signed [COORD_WIDTH-1:0]       bx,
	input  logic signed [COORD_WIDTH-1:0]       by_coord,
	input  logic signed [COORD_WIDTH-1:0]       cx,
	input  logic signed [COORD_WIDTH-1:0]       cy,
	output logic                                done,
	output logic [tcr_pkg::TAG_W-1:0]           tag_out,
	output logic [tcr_pkg::RADIUS_W-1:0]        radius,
	output logic                                degenerate
);

	localparam int unsigned TW   = tcr_pkg::TAG_W;
	localparam int unsigned QW   = tcr_pkg::RADIUS_W;
	localparam int unsigned DW   = COORD_WIDTH + 1;
	localparam int unsigned SQW  = 2 * DW + 1;
	localparam int unsigned EW   = (SQW + 1) / 2;
	localparam int unsigned FW   = EW + 2;
	localparam int unsigned P2W  = 2 * FW;
	localparam int unsigned PW   = 4 * FW;
	localparam int unsigned WW   = (PW + 1) / 2;
	localparam int unsigned ABW  = 2 * EW;
	localparam int unsigned ABCW = 3 * EW;
	localparam int unsigned NSH  = (FRAC_BITS < tcr_pkg::OUT_FRAC) ?
		tcr_pkg::OUT_FRAC - FRAC_BITS : 0;
	localparam int unsigned DSH  = (FRAC_BITS > tcr_pkg::OUT_FRAC) ?
		FRAC_BITS - tcr_pkg::OUT_FRAC : 0;
	localparam int unsigned NW   = ABCW + NSH;
	localparam int unsigned DENW = WW + DSH;
	localparam int unsigned DVW  = (NW > DENW + QW) ? NW : DENW + QW;
	localparam int unsigned LATENCY = 2 + EW + 4 + WW + 1 + QW + 1;

	// the pipeline never holds off a transfer
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1: edge vectors as absolute differences
	logic                       vld_s1;
	logic [TW-1:0]              tag_s1;
	logic [2:0][DW-1:0]         dx_s1;
	logic [2:0][DW-1:0]         dy_s1;
	logic [2:0][DW-1:0]         dx_c;
	logic [2:0][DW-1:0]         dy_c;

	function automatic logic [DW-1:0] abs_diff(input logic [COORD_WIDTH-1:0] p,
		input logic [COORD_WIDTH-1:0] q);
		logic [DW-1:0] d;
		d = {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
		return d[DW-1] ? DW'(-d) : d;
	endfunction

	always_comb begin
		dx_c[0] = abs_diff(ax, bx);
		dy_c[0] = abs_diff(ay, by_coord);
		dx_c[1] = abs_diff(bx, cx);
		dy_c[1] = abs_diff(by_coord, cy);
		dx_c[2] = abs_diff(cx, ax);
		dy_c[2] = abs_diff(cy, ay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= triangle_id;
		dx_s1  <= dx_c;
		dy_s1  <= dy_c;
	end

	// stage 2: squared edge lengths
	logic                       vld_s2;
	logic [TW-1:0]              tag_s2;
	logic [2:0][SQW-1:0]        sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		for (int e = 0; e < 3; e++) begin
			sq_s2[e] <= SQW'(dx_s1[e]) * SQW'(dx_s1[e]) + SQW'(dy_s1[e]) * SQW'(dy_s1[e]);
		end
	end

	// edge lengths, three lanes in lock step
	logic                       edge_vld;
	logic [2:0][EW-1:0]         edge_len;
	logic [TW-1:0]              edge_tag;

	tcr_sqrt_pipe #(
		.LANES (3),
		.RW    (SQW),
		.SBW   (TW)
	) u_edge_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_rad    (sq_s2),
		.in_sb     (tag_s2),
		.out_valid (edge_vld),
		.out_root  (edge_len),
		.out_sb    (edge_tag)
	);

	// stage 3: heron factors, first product of abc
	logic                       vld_s3;
	logic [TW-1:0]              tag_s3;
	logic [FW-1:0]              sum_s3;
	logic [FW-1:0]              f2_s3;
	logic [FW-1:0]              f3_s3;
	logic [FW-1:0]              f4_s3;
	logic                       neg_s3;
	logic [ABW-1:0]             ab_s3;
	logic [EW-1:0]              ec_s3;
	logic [FW-1:0]              f2_c;
	logic [FW-1:0]              f3_c;
	logic [FW-1:0]              f4_c;

	always_comb begin
		f2_c = FW'(edge_len[1]) + FW'(edge_len[2]) - FW'(edge_len[0]);
		f3_c = FW'(edge_len[0]) + FW'(edge_len[2]) - FW'(edge_len[1]);
		f4_c = FW'(edge_len[0]) + FW'(edge_len[1]) - FW'(edge_len[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= edge_vld;
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= edge_tag;
		sum_s3 <= FW'(edge_len[0]) + FW'(edge_len[1]) + FW'(edge_len[2]);
		f2_s3  <= f2_c;
		f3_s3  <= f3_c;
		f4_s3  <= f4_c;
		neg_s3 <= f2_c[FW-1] | f3_c[FW-1] | f4_c[FW-1];
		ab_s3  <= ABW'(edge_len[0]) * ABW'(edge_len[1]);
		ec_s3  <= edge_len[2];
	end

	// stage 4: heron pair products, abc partial products
	logic                       vld_s4;
	logic [TW-1:0]              tag_s4;
	logic [P2W-1:0]             p1_s4;
	logic [P2W-1:0]             p2_s4;
	logic                       neg_s4;
	logic [ABW-1:0]             abc_hi_s4;
	logic [ABW-1:0]             abc_lo_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s4    <= tag_s3;
		p1_s4     <= P2W'(sum_s3) * P2W'(f2_s3);
		p2_s4     <= P2W'(f3_s3) * P2W'(f4_s3);
		neg_s4    <= neg_s3;
		abc_hi_s4 <= ABW'(ab_s3[ABW-1:EW]) * ABW'(ec_s3);
		abc_lo_s4 <= ABW'(ab_s3[EW-1:0]) * ABW'(ec_s3);
	end

	// stage 5: heron partial products, abc sum
	logic                       vld_s5;
	logic [TW-1:0]              tag_s5;
	logic [P2W-1:0]             hh_s5;
	logic [P2W-1:0]             hl_s5;
	logic [P2W-1:0]             lh_s5;
	logic [P2W-1:0]             ll_s5;
	logic                       neg_s5;
	logic [ABCW-1:0]            abc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tag_s5 <= tag_s4;
		hh_s5  <= P2W'(p1_s4[P2W-1:FW]) * P2W'(p2_s4[P2W-1:FW]);
		hl_s5  <= P2W'(p1_s4[P2W-1:FW]) * P2W'(p2_s4[FW-1:0]);
		lh_s5  <= P2W'(p1_s4[FW-1:0]) * P2W'(p2_s4[P2W-1:FW]);
		ll_s5  <= P2W'(p1_s4[FW-1:0]) * P2W'(p2_s4[FW-1:0]);
		neg_s5 <= neg_s4;
		abc_s5 <= (ABCW'(abc_hi_s4) << EW) + ABCW'(abc_lo_s4);
	end

	// stage 6: heron product, clamped to zero on a broken triangle
	logic                       vld_s6;
	logic [TW-1:0]              tag_s6;
	logic [PW-1:0]              prod_s6;
	logic [ABCW-1:0]            abc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		tag_s6 <= tag_s5;
		abc_s6 <= abc_s5;
		if (neg_s5) begin
			prod_s6 <= '0;
		end else begin
			prod_s6 <= (PW'(hh_s5) << P2W) + ((PW'(hl_s5) + PW'(lh_s5)) << FW) + PW'(ll_s5);
		end
	end

	// four times the area
	logic                       area_vld;
	logic [0:0][WW-1:0]         area_w;
	logic [TW+ABCW-1:0]         area_sb;
	logic [TW-1:0]              area_tag;
	logic [ABCW-1:0]            area_abc;

	tcr_sqrt_pipe #(
		.LANES (1),
		.RW    (PW),
		.SBW   (TW + ABCW)
	) u_area_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.in_rad    (prod_s6),
		.in_sb     ({tag_s6, abc_s6}),
		.out_valid (area_vld),
		.out_root  (area_w),
		.out_sb    (area_sb)
	);

	assign area_tag = area_sb[TW+ABCW-1:ABCW];
	assign area_abc = area_sb[ABCW-1:0];

	// stage 7: scale operands, flag zero area and overflow
	logic                       vld_s7;
	logic [TW-1:0]              tag_s7;
	logic [NW-1:0]              num_s7;
	logic [DENW-1:0]            den_s7;
	logic                       degen_s7;
	logic                       sat_s7;
	logic [NW-1:0]              num_c;
	logic [DENW-1:0]            den_c;

	always_comb begin
		num_c = NW'(area_abc) << NSH;
		den_c = DENW'(area_w[0]) << DSH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= area_vld;
		end
	end

	always_ff @(posedge clk) begin
		tag_s7   <= area_tag;
		num_s7   <= num_c;
		den_s7   <= den_c;
		degen_s7 <= (area_w[0] == '0);
		sat_s7   <= (DVW'(num_c) >= (DVW'(den_c) << QW));
	end

	// radius divider, one quotient bit per stage, msb first
	logic                       dv_vld [0:QW];
	logic [TW-1:0]              dv_tag [0:QW];
	logic [NW-1:0]              dv_rem [0:QW-1];
	logic [DENW-1:0]            dv_den [0:QW-1];
	logic [QW-1:0]              dv_quo [0:QW];
	logic                       dv_ovf [0:QW];
	logic                       dv_degen [0:QW];

	always_comb begin
		dv_vld[0]   = vld_s7;
		dv_tag[0]   = tag_s7;
		dv_rem[0]   = num_s7;
		dv_den[0]   = den_s7;
		dv_quo[0]   = '0;
		dv_ovf[0]   = sat_s7;
		dv_degen[0] = degen_s7;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int unsigned BIT = QW - 1 - k;
		logic [DVW-1:0] part;
		logic           hit;
		logic [QW-1:0]  nquo;

		always_comb begin
			part = DVW'(dv_den[k]) << BIT;
			hit  = part <= DVW'(dv_rem[k]);
			nquo = dv_quo[k];
			nquo[BIT] = hit;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k+1] <= 1'b0;
			end else begin
				dv_vld[k+1] <= dv_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_tag[k+1]   <= dv_tag[k];
			dv_quo[k+1]   <= nquo;
			dv_ovf[k+1]   <= dv_ovf[k];
			dv_degen[k+1] <= dv_degen[k];
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				dv_den[k+1] <= dv_den[k];
				if (hit) begin
					dv_rem[k+1] <= NW'(DVW'(dv_rem[k]) - part);
				end else begin
					dv_rem[k+1] <= dv_rem[k];
				end
			end
		end
	end

	// output register, saturate on zero area or overflow
	logic                       done_q;
	logic [TW-1:0]              tag_q;
	logic [QW-1:0]              radius_q;
	logic                       degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld[QW];
		end
	end

	always_ff @(posedge clk) begin
		tag_q   <= dv_tag[QW];
		degen_q <= dv_degen[QW];
		if (dv_degen[QW] || dv_ovf[QW]) begin
			radius_q <= '1;
		end else begin
			radius_q <= dv_quo[QW];
		end
	end

	assign done       = done_q;
	assign tag_out    = tag_q;
	assign radius     = radius_q;
	assign degenerate = degen_q;

`ifndef SYNTHESIS
	// every accepted triangle leaves after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted triangle did not produce a result on time");

	// no result without a triangle accepted that many cycles before
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching accepted triangle");

	// a degenerate triangle reports a full scale radius
	a_degen_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> radius == '1)
		else $error("degenerate result without full scale radius");

	// zero area at the divider input marks the item degenerate at the output
	a_degen_track: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && degen_s7 |-> ##(QW + 1) (done && degenerate))
		else $error("zero area lost on the way through the divider");
`endif

endmodule
